>>> sv/ppit_pkg.sv
`default_nettype none
package ppit_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = ADDR_BITS + 1;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int MIN_VERTICES = 3;

  localparam int REQ_BITS       = 2;
  localparam int IN_FIELD_BITS  = REQ_BITS + 2 * COORD_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2;
  localparam int OUT_TDATA_BITS = 8;

  localparam int X_LSB = REQ_BITS;
  localparam int Y_LSB = REQ_BITS + COORD_BITS;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEST   = 2'd2
  } req_type_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
  } edge_t;

  typedef struct packed {
    logic done;
    logic odd;
  } edge_res_t;

endpackage
`default_nettype wire

>>> sv/ppit_edge_unit.sv
`default_nettype none
module ppit_edge_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  ppit_pkg::coord_t    px,
  input  ppit_pkg::coord_t    py,
  input  ppit_pkg::edge_t     edge_in,
  output ppit_pkg::edge_res_t res
);

  typedef logic signed [ppit_pkg::DIFF_BITS-1:0] diff_t;
  typedef logic signed [ppit_pkg::PROD_BITS-1:0] prod_t;

  // difference stage
  logic  d_valid;
  logic  d_last;
  logic  d_cross;
  logic  d_dy_pos;
  diff_t d_dxab;
  diff_t d_pya;
  diff_t d_pxa;
  diff_t d_dy;

  // product stage
  logic  p_valid;
  logic  p_last;
  logic  p_cross;
  logic  p_dy_pos;
  prod_t p_lhs;
  prod_t p_rhs;

  logic  parity;
  logic  hit;
  diff_t dy_next;

  always_comb begin
    dy_next = diff_t'(edge_in.yb) - diff_t'(edge_in.ya);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      d_valid <= edge_in.valid;
      p_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_last   <= edge_in.last;
    d_cross  <= (edge_in.ya > py) != (edge_in.yb > py);
    d_dy_pos <= dy_next > 0;
    d_dy     <= dy_next;
    d_dxab   <= diff_t'(edge_in.xb) - diff_t'(edge_in.xa);
    d_pya    <= diff_t'(py) - diff_t'(edge_in.ya);
    d_pxa    <= diff_t'(px) - diff_t'(edge_in.xa);

    p_last   <= d_last;
    p_cross  <= d_cross;
    p_dy_pos <= d_dy_pos;
    p_lhs    <= prod_t'(d_dxab) * prod_t'(d_pya);
    p_rhs    <= prod_t'(d_pxa) * prod_t'(d_dy);
  end

  always_comb begin
    if (p_dy_pos) begin
      hit = p_cross && (p_lhs <= p_rhs);
    end else begin
      hit = p_cross && (p_lhs >= p_rhs);
    end
  end

  always_ff @(posedge clk) begin
    res.odd <= parity ^ (p_valid && hit);
    if (rst) begin
      parity   <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= p_valid && p_last;
      if (start) begin
        parity <= 1'b0;
      end else if (p_valid) begin
        parity <= parity ^ hit;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/polygon_point_inside_test_unit.sv
`default_nettype none
// Point-in-polygon tester, even-odd rule, vertex table of up to 64 entries.
// Input stream s_*: one transfer per request (clear table, append vertex,
// test point). Output stream m_*: exactly one transfer per request, in order.
// Clear and append pass through the finish state to the output register.
// A test with n >= 3 stored vertices reads one vertex per cycle from the
// vertex memory (one registered read port) and forms one edge per cycle,
// the closing edge last, through a difference, multiply and compare
// pipeline. With fewer than 3 vertices a test skips the walk and answers
// inside.
// One request is worked at a time; s_tready is high while no request is in
// flight, even when a finished result still sits in the output register.
// When m_tready stays low the result is held there; the next request is
// still taken, and its result waits until the output register is free.
// Reset empties the table (the count goes to zero; memory contents are not
// cleared and need not be) and drops any pending result.
module polygon_point_inside_test_unit (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire [ppit_pkg::IN_TDATA_BITS-1:0]  s_tdata,  // req_type, x, y, zero pad
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [ppit_pkg::OUT_TDATA_BITS-1:0] m_tdata  // inside_res, status, zero pad
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  typedef logic [ppit_pkg::ADDR_BITS-1:0] addr_t;
  typedef logic [ppit_pkg::CNT_BITS-1:0]  cnt_t;

  state_t state;
  cnt_t   vertex_count;
  cnt_t   iss;

  logic   s_xfer;
  logic [ppit_pkg::REQ_BITS-1:0] req;
  ppit_pkg::coord_t x_in;
  ppit_pkg::coord_t y_in;

  ppit_pkg::coord_t px;
  ppit_pkg::coord_t py;
  logic   res_inside;
  logic   res_status;

  logic [2*ppit_pkg::COORD_BITS-1:0] vmem [ppit_pkg::MAX_VERTICES];
  logic [2*ppit_pkg::COORD_BITS-1:0] rd_data;
  logic   wr_en;
  logic   rd_en;
  addr_t  rd_addr;
  addr_t  last_addr;

  logic   rv;
  logic   r_first;
  logic   r_last;
  logic   close_pend;
  ppit_pkg::coord_t first_x;
  ppit_pkg::coord_t first_y;
  ppit_pkg::coord_t prev_x;
  ppit_pkg::coord_t prev_y;
  ppit_pkg::coord_t cur_x;
  ppit_pkg::coord_t cur_y;

  ppit_pkg::edge_t     edge_in;
  ppit_pkg::edge_res_t edge_res;
  logic   start;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign req      = s_tdata[ppit_pkg::REQ_BITS-1:0];
  assign x_in     = s_tdata[ppit_pkg::X_LSB +: ppit_pkg::COORD_BITS];
  assign y_in     = s_tdata[ppit_pkg::Y_LSB +: ppit_pkg::COORD_BITS];
  assign out_free = !m_tvalid || m_tready;

  assign start = s_xfer && (req == ppit_pkg::REQ_TEST);
  assign wr_en = s_xfer && (req == ppit_pkg::REQ_APPEND) &&
                 (vertex_count < cnt_t'(ppit_pkg::MAX_VERTICES));
  assign rd_en = (start && (vertex_count >= cnt_t'(ppit_pkg::MIN_VERTICES))) ||
                 ((state == S_WALK) && (iss < vertex_count));
  assign rd_addr   = (state == S_WALK) ? iss[ppit_pkg::ADDR_BITS-1:0] : addr_t'(0);
  assign last_addr = addr_t'(vertex_count - cnt_t'(1));

  assign cur_x = rd_data[ppit_pkg::COORD_BITS-1:0];
  assign cur_y = rd_data[2*ppit_pkg::COORD_BITS-1:ppit_pkg::COORD_BITS];

  // vertex memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[vertex_count[ppit_pkg::ADDR_BITS-1:0]] <= {y_in, x_in};
    end
    if (rd_en) begin
      rd_data <= vmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv         <= 1'b0;
      close_pend <= 1'b0;
    end else begin
      rv         <= rd_en;
      close_pend <= rv && r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      r_first <= (rd_addr == addr_t'(0));
      r_last  <= (rd_addr == last_addr);
    end
    if (rv) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
      if (r_first) begin
        first_x <= cur_x;
        first_y <= cur_y;
      end
    end
  end

  // closing edge runs from the first vertex to the last one
  always_comb begin
    edge_in.valid = (rv && !r_first) || close_pend;
    edge_in.last  = close_pend;
    if (close_pend) begin
      edge_in.xa = first_x;
      edge_in.ya = first_y;
      edge_in.xb = prev_x;
      edge_in.yb = prev_y;
    end else begin
      edge_in.xa = prev_x;
      edge_in.ya = prev_y;
      edge_in.xb = cur_x;
      edge_in.yb = cur_y;
    end
  end

  ppit_edge_unit u_edge (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .px      (px),
    .py      (py),
    .edge_in (edge_in),
    .res     (edge_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      iss          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_xfer) begin
            state <= S_FINISH;
            case (req)
              ppit_pkg::REQ_CLEAR: begin
                vertex_count <= '0;
              end
              ppit_pkg::REQ_APPEND: begin
                if (wr_en) begin
                  vertex_count <= vertex_count + cnt_t'(1);
                end
              end
              ppit_pkg::REQ_TEST: begin
                if (vertex_count >= cnt_t'(ppit_pkg::MIN_VERTICES)) begin
                  state <= S_WALK;
                  iss   <= cnt_t'(1);
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_WALK: begin
          if (iss < vertex_count) begin
            iss <= iss + cnt_t'(1);
          end
          if (edge_res.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      px         <= x_in;
      py         <= y_in;
      res_inside <= (req == ppit_pkg::REQ_TEST) &&
                    (vertex_count < cnt_t'(ppit_pkg::MIN_VERTICES));
      res_status <= (req == ppit_pkg::REQ_APPEND) && !wr_en;
    end else if ((state == S_WALK) && edge_res.done) begin
      res_inside <= edge_res.odd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      m_tdata <= {(ppit_pkg::OUT_TDATA_BITS - ppit_pkg::OUT_FIELD_BITS)'(0),
                  res_status, res_inside};
    end
  end

endmodule
`default_nettype wire

>>> sv/ppit_checker.sv
`default_nettype none
module ppit_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                s_tvalid,
  input wire                                s_tready,
  input wire                                m_tvalid,
  input wire                                m_tready,
  input wire [ppit_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

  logic s_xfer;
  assign s_xfer = s_tvalid && s_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> !s_tready)
    else $error("second request taken while one is in flight");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("inside and dropped flags both set");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ppit_pkg::OUT_TDATA_BITS-1:ppit_pkg::OUT_FIELD_BITS] == '0))
    else $error("output pad bits not zero");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind polygon_point_inside_test_unit ppit_checker u_ppit_checker (.*);
`default_nettype wire

>>> dv/testbench.sv
module testbench;
  import ppit_pkg::*;

  localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;

  class inside_scoreboard;
    coord_t vert_x[MAX_VERTICES];
    coord_t vert_y[MAX_VERTICES];
    int unsigned vert_count;
    logic [1:0] expected_answers[$];  // status, in_poly
    int errors;

    function new();
      vert_count = 0;
      errors = 0;
    endfunction

    function bit edge_crossed(longint px, longint py, int unsigned ia, int unsigned ib);
      longint xa, ya, xb, yb, dy, lhs, rhs;
      xa = vert_x[ia];
      ya = vert_y[ia];
      xb = vert_x[ib];
      yb = vert_y[ib];
      if ((ya > py) == (yb > py)) return 1'b0;
      dy = yb - ya;
      lhs = (xb - xa) * (py - ya);
      rhs = (px - xa) * dy;
      return (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    function void note_request(logic [REQ_BITS-1:0] req, coord_t x, coord_t y);
      logic in_poly, status;
      int unsigned hits;
      in_poly = 1'b0;
      status = 1'b0;
      case (req)
        REQ_CLEAR: vert_count = 0;
        REQ_APPEND: begin
          if (vert_count >= MAX_VERTICES) begin
            status = 1'b1;
          end else begin
            vert_x[vert_count] = x;
            vert_y[vert_count] = y;
            vert_count++;
          end
        end
        REQ_TEST: begin
          if (vert_count < MIN_VERTICES) begin
            in_poly = 1'b1;
          end else begin
            hits = 0;
            for (int unsigned i = 1; i < vert_count; i++)
              if (edge_crossed(x, y, i - 1, i)) hits++;
            if (edge_crossed(x, y, 0, vert_count - 1)) hits++;
            in_poly = hits[0];
          end
        end
        default: ;
      endcase
      expected_answers.insert(expected_answers.size(), {status, in_poly});
    endfunction

    function void check_answer(logic [OUT_TDATA_BITS-1:0] tdata);
      logic [1:0] want;
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result in_poly=%0b status=%0b", $time, tdata[0], tdata[1]);
        return;
      end
      want = expected_answers.pop_front();
      if (tdata[0] !== want[0]) begin
        errors++;
        $display("%0t: in_poly expected %0b actual %0b", $time, want[0], tdata[0]);
      end
      if (tdata[1] !== want[1]) begin
        errors++;
        $display("%0t: status expected %0b actual %0b", $time, want[1], tdata[1]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int items_sent = 0;
  int stall_cycles = 0;
  inside_scoreboard answers = new();

  polygon_point_inside_test_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // transfer monitor on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        answers.note_request(s_tdata[REQ_BITS-1:0], s_tdata[X_LSB +: COORD_BITS],
                             s_tdata[Y_LSB +: COORD_BITS]);
      if (m_tvalid && m_tready) answers.check_answer(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_around(int c, int span);
    int offs;
    offs = int'($urandom_range(2 * span)) - span;
    return clamp_coord(c + offs);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic send_item(input logic [REQ_BITS-1:0] req, input int x, input int y);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_BITS'({coord_t'(y), coord_t'(x), req});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (req != REQ_UNUSED) items_sent++;
  endtask

  // mostly random polygons followed by tests, the rest random requests
  task automatic random_part(input int count, input bit fill_first);
    int goal, n_vert, span, cx, cy, px, py, pick, n_tests, idx;
    int vx[$], vy[$];
    bit first;
    goal = items_sent + count;
    first = fill_first;
    while (items_sent < goal) begin
      if (first || $urandom_range(99) < 80) begin
        if (first) n_vert = MAX_VERTICES + 2;
        else if ($urandom_range(19) == 0) n_vert = $urandom_range(60, 68);
        else n_vert = $urandom_range(0, 10);
        case ($urandom_range(2))
          0: span = 20;
          1: span = 2000;
          default: span = 32767;
        endcase
        cx = rand_coord();
        cy = rand_coord();
        if (first || $urandom_range(9) != 0) begin
          send_item(REQ_CLEAR, rand_coord(), rand_coord());
          vx.delete();
          vy.delete();
        end
        repeat (n_vert) begin
          px = rand_around(cx, span);
          py = rand_around(cy, span);
          vx.insert(vx.size(), px);
          vy.insert(vy.size(), py);
          send_item(REQ_APPEND, px, py);
        end
        n_tests = $urandom_range(2, 8);
        repeat (n_tests) begin
          pick = $urandom_range(9);
          if (pick < 6) begin
            px = rand_around(cx, span);
            py = rand_around(cy, span);
          end else if (pick < 9 && vx.size() > 0) begin
            // on or next to a stored vertex
            idx = $urandom_range(vx.size() - 1);
            px = clamp_coord(vx[idx] + int'($urandom_range(2)) - 1);
            py = clamp_coord(vy[idx] + int'($urandom_range(2)) - 1);
          end else begin
            px = rand_coord();
            py = rand_coord();
          end
          send_item(REQ_TEST, px, py);
        end
        first = 1'b0;
      end else begin
        send_item(REQ_BITS'($urandom_range(3)), rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 23;
    receiver_idle_pct = 87;

    // empty table, unused request, full-range square
    send_item(REQ_TEST, -32768, 32767);
    send_item(REQ_UNUSED, 32767, -32768);
    send_item(REQ_APPEND, -32768, -32768);
    send_item(REQ_APPEND, 32767, -32768);
    send_item(REQ_TEST, 12345, -32768);
    send_item(REQ_APPEND, 32767, 32767);
    send_item(REQ_APPEND, -32768, 32767);
    send_item(REQ_TEST, 0, 0);
    send_item(REQ_TEST, -32768, -32768);
    send_item(REQ_TEST, 32767, 32767);
    send_item(REQ_TEST, 32767, 0);
    send_item(REQ_TEST, -32768, 0);
    send_item(REQ_TEST, 0, 32767);
    send_item(REQ_TEST, 0, -32768);
    // triangle with falling edges
    send_item(REQ_CLEAR, 0, 0);
    send_item(REQ_APPEND, 0, 100);
    send_item(REQ_APPEND, 100, -100);
    send_item(REQ_APPEND, -100, -100);
    send_item(REQ_TEST, 0, 0);
    send_item(REQ_TEST, 0, 100);
    send_item(REQ_TEST, 50, 0);
    send_item(REQ_TEST, -50, 0);
    send_item(REQ_TEST, 101, -99);
    send_item(REQ_UNUSED, -1, -1);

    random_part(170, 1'b1);
    sender_idle_pct = 87;
    receiver_idle_pct = 23;
    random_part(170, 1'b0);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    random_part(170, 1'b1);

    s_tvalid <= 1'b0;
    while (answers.expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (answers.errors == 0 && answers.expected_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ppit_pkg.sv
sv/ppit_edge_unit.sv
sv/polygon_point_inside_test_unit.sv
sv/ppit_checker.sv
dv/testbench.sv
